// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define MFBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define MFBP_ASSERT_IMPL(lbl, cond, prop, msg) \
	`MFBP_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

// File: hw/rtl/mfbp_pkg.sv
// ---------------------------------------------------------------------------
// mfbp_pkg
// Types and constants shared by the MSB-first bit packer modules.
// ---------------------------------------------------------------------------
package mfbp_pkg;

	// Widest field taken from one item, and the resulting bit count cap.
	localparam int MAX_FIELD_BITS = 32;
	localparam logic [5:0] FIELD_CAP = (MAX_FIELD_BITS < 32) ? 6'(MAX_FIELD_BITS) : 6'd32;

	// Accumulator plus one full field gives a 40-bit window of five bytes.
	localparam int WIN_W   = 40;
	localparam int BYTE_W  = 8;

	// Decoupling queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified item: left-aligned bytes, how many to commit, flush flag.
	typedef struct packed {
		logic [WIN_W-1:0] bytes;
		logic [2:0]       cnt;
		logic             eom;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: hw/rtl/mfbp_front.sv
// ---------------------------------------------------------------------------
// mfbp_front
// Merges each field into the partial byte and hands whole bytes to the queue.
// ---------------------------------------------------------------------------
module mfbp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [31:0]          value,
	input  logic [5:0]           bit_count,
	input  logic                 end_of_message,
	output mfbp_pkg::entry_t     entry
);

	logic [7:0]  acc_q;
	logic [2:0]  fill_q;

	logic [5:0]  n_sat;
	logic [5:0]  shamt;
	logic [31:0] aligned;
	logic [mfbp_pkg::WIN_W-1:0] win;
	logic [mfbp_pkg::WIN_W-1:0] win_rest;
	logic [5:0]  total;
	logic [2:0]  k;
	logic [2:0]  rem;

	always_comb begin
		n_sat   = (bit_count > mfbp_pkg::FIELD_CAP) ? mfbp_pkg::FIELD_CAP : bit_count;
		shamt   = 6'(6'd32 - n_sat);
		aligned = (n_sat == 6'd0) ? 32'd0 : (value << shamt);
		win     = {acc_q, 32'd0} | ({aligned, 8'd0} >> fill_q);
		total   = 6'(fill_q) + n_sat;
		k       = total[5:3];
		rem     = total[2:0];
		// Bring the byte that stays partial to the top.
		win_rest = win << {k, 3'b000};

		entry.bytes = win;
		entry.eom   = end_of_message;
		entry.cnt   = k + 3'((end_of_message && (rem != 3'd0)) ? 1 : 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (end_of_message) begin
				acc_q  <= '0;
				fill_q <= '0;
			end else begin
				acc_q  <= win_rest[mfbp_pkg::WIN_W-1 -: 8];
				fill_q <= rem;
			end
		end
	end

endmodule

// File: hw/rtl/mfbp_queue.sv
// ---------------------------------------------------------------------------
// mfbp_queue
// Short register FIFO between the classifying front and the byte back end.
// ---------------------------------------------------------------------------
module mfbp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mfbp_pkg::entry_t      push_entry,
	input  logic                  pop,
	output mfbp_pkg::entry_t      head,
	output mfbp_pkg::q_status_t   status
);

	mfbp_pkg::entry_t                mem_q [mfbp_pkg::QUEUE_DEPTH];
	logic [mfbp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mfbp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mfbp_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign status.full  = (count_q == mfbp_pkg::QCNT_W'(mfbp_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : mfbp_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : mfbp_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/mfbp_back.sv
// ---------------------------------------------------------------------------
// mfbp_back
// Commits queued bytes one per cycle while the receiver is ready, tracks position and overflow.
// ---------------------------------------------------------------------------
module mfbp_back #(
	parameter int MAX_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfbp_pkg::entry_t      head,
	input  logic                  head_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            data_byte,
	output logic [7:0]            byte_index,
	output logic                  final_byte,
	output logic                  overflow
);

	localparam int PW = $clog2(MAX_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic          ovf_q;
	logic [2:0]    j_q;
	logic          valid_q;
	logic [7:0]    data_q;
	logic [7:0]    idx_q;
	logic          fin_q;
	logic          ovfo_q;

	logic          advance;
	logic          step;
	logic          in_bytes;
	logic          last;
	logic          at_max;
	logic [mfbp_pkg::WIN_W-1:0] sh;

	logic          emit;
	logic [7:0]    emit_data;
	logic          emit_fin;
	logic          clr_msg;
	logic          inc_pos;
	logic          set_ovf;
	logic [2:0]    j_next;

	assign advance  = !valid_q || out_ready;
	assign step     = advance && head_valid;
	assign in_bytes = (j_q < head.cnt);
	assign last     = (3'(j_q + 3'd1) == head.cnt);
	assign at_max   = (pos_q >= PW'(MAX_BYTES));
	assign sh       = head.bytes << {j_q, 3'b000};

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_data = sh[mfbp_pkg::WIN_W-1 -: 8];
		emit_fin  = 1'b0;
		clr_msg   = 1'b0;
		inc_pos   = 1'b0;
		set_ovf   = 1'b0;
		j_next    = j_q;
		if (step) begin
			if (in_bytes) begin
				if (!at_max) begin
					emit     = 1'b1;
					inc_pos  = 1'b1;
					emit_fin = last && head.eom;
					if (last) begin
						pop     = 1'b1;
						j_next  = 3'd0;
						clr_msg = head.eom;
					end else begin
						j_next = 3'(j_q + 3'd1);
					end
				end else begin
					// Drop the byte; a dropped final byte leaves a status result.
					set_ovf = 1'b1;
					if (last && !head.eom) begin
						pop    = 1'b1;
						j_next = 3'd0;
					end else begin
						j_next = 3'(j_q + 3'd1);
					end
				end
			end else begin
				pop    = 1'b1;
				j_next = 3'd0;
				if (head.eom) begin
					emit      = 1'b1;
					emit_data = 8'd0;
					emit_fin  = 1'b1;
					clr_msg   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			j_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			j_q <= j_next;
			if (clr_msg) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (inc_pos) begin
					pos_q <= PW'(pos_q + 1'b1);
				end
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			if (advance) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_q <= emit_data;
			idx_q  <= 8'(pos_q);
			fin_q  <= emit_fin;
			ovfo_q <= ovf_q;
		end
	end

	assign out_valid  = valid_q;
	assign data_byte  = data_q;
	assign byte_index = idx_q;
	assign final_byte = fin_q;
	assign overflow   = ovfo_q;

endmodule

// File: hw/rtl/msb_first_bit_packer_core.sv
// ---------------------------------------------------------------------------
// msb_first_bit_packer_core
// MSB-first bitstream writer: packs variable-width fields into a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave stream s_axis: one transaction per field. tdata carries the value
//    (bits 31:0) and the bit count 1..32 (bits 37:32); tlast ends the message,
//    padding the partial byte with zeros and emitting it.
//  - Master stream m_axis: one transaction per byte. tdata carries the byte
//    (bits 7:0, first bit in bit 7) and its index in the message (15:8);
//    tlast marks the last result of a message, tuser flags dropped bytes.
//  - Bytes beyond MAX_BYTES are dropped; a message whose final byte was
//    dropped, or that ends with nothing pending, closes with a status
//    transaction (data 0, tlast 1, tuser = overflow).
//  - Path: an accepted field is written into the queue, then its first byte
//    is registered in the output register. The back end emits or drops a
//    field's bytes one at a time while the output register can advance, and
//    pops the field after its last byte or the status result that a dropped
//    final byte leaves. The front accepts a field each cycle while the queue has room.
//  - Reset clears the partial byte, the byte position and the queue; no
//    clearing pass is needed.
//  - A stalled receiver holds the output register; the queue keeps taking
//    fields until it fills, then tready drops.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_packer_core #(
	parameter int MAX_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input fields
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // value[31:0], bit_count[37:32], zero pad
	input  logic        s_axis_tlast,   // end_of_message
	// Output bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // data_byte[7:0], byte_index[15:8]
	output logic        m_axis_tlast,   // final_byte
	output logic [0:0]  m_axis_tuser    // overflow
);

	logic                   in_accept;
	mfbp_pkg::entry_t       front_entry;
	mfbp_pkg::entry_t       head;
	mfbp_pkg::q_status_t    q_stat;
	logic                   pop;
	logic [7:0]             data_byte;
	logic [7:0]             byte_index;
	logic                   final_byte;
	logic                   overflow;

	// Take a field whenever the queue has room.
	assign s_axis_tready = !q_stat.full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Front: merge the field with the partial byte, classify its bytes.
	mfbp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_accept),
		.value          (s_axis_tdata[31:0]),
		.bit_count      (s_axis_tdata[37:32]),
		.end_of_message (s_axis_tlast),
		.entry          (front_entry)
	);

	// Queue: decouple front from a stalled back end.
	mfbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_entry (front_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_stat)
	);

	// Back: commit bytes, drop past the limit, mark the message end.
	mfbp_back #(
		.MAX_BYTES (MAX_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.final_byte (final_byte),
		.overflow   (overflow)
	);

	assign m_axis_tdata = {byte_index, data_byte};
	assign m_axis_tlast = final_byte;
	assign m_axis_tuser = overflow;

	// Queue occupancy flags never contradict each other.
	`MFBP_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue both full and empty")
	// Overflow can only be reported on the closing result of a message.
	`MFBP_ASSERT_IMPL(a_ovf_final, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "overflow not final")
	// The back end never pops an empty queue.
	`MFBP_ASSERT_IMPL(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule
